### rtl/siph_pkg.sv
// SipHash-2-4 tag engine: shared types, constants and the SipRound function.
// Used by siph_front, siph_fifo, siph_back and siphash_2_4_tag_top.
package siph_pkg;

	localparam logic [63:0] IV0 = 64'h736f6d6570736575;
	localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2 = 64'h6c7967656e657261;
	localparam logic [63:0] IV3 = 64'h7465646279746573;
	localparam logic [7:0]  FIN_XOR = 8'hff;

	localparam int QDEPTH = 2;
	localparam int QPTRW  = $clog2(QDEPTH);
	localparam int QCNTW  = $clog2(QDEPTH + 1);

	typedef logic [63:0] word_t;

	typedef struct packed {
		word_t       v0;
		word_t       v1;
		word_t       v2;
		word_t       v3;
	} vstate_t;

	typedef struct packed {
		word_t       data;
		logic [7:0]  len;
		logic        first;
		logic        last;
		logic        full;
	} entry_t;

	function automatic vstate_t sip_round(input vstate_t s);
		word_t a, b, c, d;
		a = s.v0;
		b = s.v1;
		c = s.v2;
		d = s.v3;
		a = a + b; b = {b[50:0], b[63:51]}; b = b ^ a; a = {a[31:0], a[63:32]};
		c = c + d; d = {d[47:0], d[63:48]}; d = d ^ c;
		a = a + d; d = {d[42:0], d[63:43]}; d = d ^ a;
		c = c + b; b = {b[46:0], b[63:47]}; b = b ^ c; c = {c[31:0], c[63:32]};
		return '{v0: a, v1: b, v2: c, v3: d};
	endfunction

endpackage

### rtl/siphash_2_4_tag_top.sv
// Throughput: one SipRound per cycle while the engine has a word and no tag waits; each
// word is absorbed and a last word finalized, a full one after an extra absorb of the length block.
// A waiting tag holds the round engine, then the input once the queue fills.
// Reset (arst_n low): keys clear to zero, queues empty, next word starts a new message.
// Top level of the SipHash-2-4 tag engine; depends on siph_pkg, siph_front, siph_fifo,
// siph_back.
module siphash_2_4_tag_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_addr,
	input  logic [63:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_word,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] tag
);

	siph_pkg::entry_t f_entry;
	siph_pkg::entry_t q_entry;
	logic             accept;
	logic             q_empty;
	logic             q_pop;
	logic             out_valid;

	assign accept = push && !full;
	assign empty  = !out_valid;

	siph_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.entry      (f_entry)
	);

	siph_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (accept),
		.wr_entry (f_entry),
		.q_full   (full),
		.rd       (q_pop),
		.q_empty  (q_empty),
		.rd_entry (q_entry)
	);

	siph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.q_empty   (q_empty),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_tag   (tag),
		.out_pop   (pop)
	);

endmodule

### rtl/siph_front.sv
// Front end: tracks message start and byte length, builds the block for each word.
// Depends on siph_pkg.
module siph_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [63:0]         data_word,
	input  logic [3:0]          byte_count,
	input  logic                last_word,
	output siph_pkg::entry_t    entry
);

	logic        in_msg_q;
	logic [7:0]  len_q;
	logic [7:0]  base;
	logic [3:0]  cnt_sat;
	logic        full;
	logic [7:0]  len_n;
	logic [63:0] mask;

	always_comb begin
		base    = in_msg_q ? len_q : 8'd0;
		cnt_sat = (byte_count > 4'd8) ? 4'd8 : byte_count;
		full    = !last_word || (cnt_sat == 4'd8);
		len_n   = full ? (base + 8'd8) : (base + {4'd0, cnt_sat});
		mask    = ~({64{1'b1}} << {cnt_sat[2:0], 3'b000});
		entry.first = !in_msg_q;
		entry.last  = last_word;
		entry.full  = full;
		entry.len   = len_n;
		entry.data  = full ? data_word : ((data_word & mask) | {len_n, 56'd0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			len_q    <= 8'd0;
		end else if (accept) begin
			in_msg_q <= !last_word;
			len_q    <= len_n;
		end
	end

endmodule

### rtl/siph_fifo.sv
// Two-entry queue between front end and round engine.
// Depends on siph_pkg.
module siph_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  siph_pkg::entry_t    wr_entry,
	output logic                q_full,
	input  logic                rd,
	output logic                q_empty,
	output siph_pkg::entry_t    rd_entry
);

	siph_pkg::entry_t                mem_q [siph_pkg::QDEPTH];
	logic [siph_pkg::QPTRW-1:0]      wp_q;
	logic [siph_pkg::QPTRW-1:0]      rp_q;
	logic [siph_pkg::QCNTW-1:0]      cnt_q;

	assign q_full   = (cnt_q == siph_pkg::QCNTW'(siph_pkg::QDEPTH));
	assign q_empty  = (cnt_q == '0);
	assign rd_entry = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNTW_ONE(wr) - QCNTW_ONE(rd);
		end
	end

	function automatic logic [siph_pkg::QCNTW-1:0] QCNTW_ONE(input logic b);
		return {{(siph_pkg::QCNTW-1){1'b0}}, b};
	endfunction

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && q_full && !rd)) else $error("queue write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && q_empty)) else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("queue count lost a write");
`endif

endmodule

### rtl/siph_back.sv
// Round engine: key registers, one SipRound per cycle unless a tag waits, finalization and tag register.
// Depends on siph_pkg.
module siph_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic                wr_addr,
	input  logic [63:0]         wr_data,
	input  logic                q_empty,
	input  siph_pkg::entry_t    q_entry,
	output logic                q_pop,
	output logic                out_valid,
	output logic [63:0]         out_tag,
	input  logic                out_pop
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_C1   = 2'd1;
	localparam logic [1:0] ST_C2   = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;
	localparam logic       REG_KEY_LOW  = 1'b0;
	localparam logic       REG_KEY_HIGH = 1'b1;

	logic [63:0]       k0_q;
	logic [63:0]       k1_q;
	logic [1:0]        state_q;
	logic [1:0]        cnt_q;
	siph_pkg::vstate_t v_q;
	siph_pkg::word_t   m_q;
	logic [7:0]        len_q;
	logic              last_q;
	logic              full_q;
	logic              out_valid_q;
	logic [63:0]       tag_q;

	siph_pkg::vstate_t v_in;
	siph_pkg::vstate_t rin;
	siph_pkg::vstate_t r;
	siph_pkg::vstate_t c2_v;
	logic              tag_we;

	always_comb begin
		if (q_entry.first) begin
			v_in = '{v0: siph_pkg::IV0 ^ k0_q, v1: siph_pkg::IV1 ^ k1_q,
			         v2: siph_pkg::IV2 ^ k0_q, v3: siph_pkg::IV3 ^ k1_q};
		end else begin
			v_in = v_q;
		end
		v_in.v3 = v_in.v3 ^ q_entry.data;
		rin     = (state_q == ST_IDLE) ? v_in : v_q;
		r       = siph_pkg::sip_round(rin);
		c2_v    = r;
		c2_v.v0 = r.v0 ^ m_q;
		if (last_q && full_q) begin
			c2_v.v3 = r.v3 ^ {len_q, 56'd0};
		end else if (last_q) begin
			c2_v.v2 = r.v2 ^ {56'd0, siph_pkg::FIN_XOR};
		end
	end

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign tag_we    = (state_q == ST_FIN) && (cnt_q == 2'd3) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k0_q <= '0;
			k1_q <= '0;
		end else if (wr_en) begin
			unique case (wr_addr)
				REG_KEY_LOW:  k0_q <= wr_data;
				REG_KEY_HIGH: k1_q <= wr_data;
				default:      k0_q <= k0_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_q <= r.v0 ^ r.v1 ^ r.v2 ^ r.v3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 2'd0;
			v_q         <= '0;
			m_q         <= '0;
			len_q       <= 8'd0;
			last_q      <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tag_we) begin
				out_valid_q <= 1'b1;
			end else if (out_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						v_q     <= r;
						m_q     <= q_entry.data;
						len_q   <= q_entry.len;
						last_q  <= q_entry.last;
						full_q  <= q_entry.full;
						state_q <= ST_C2;
					end
				end
				ST_C1: begin
					v_q     <= r;
					state_q <= ST_C2;
				end
				ST_C2: begin
					v_q <= c2_v;
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (full_q) begin
						m_q     <= {len_q, 56'd0};
						full_q  <= 1'b0;
						state_q <= ST_C1;
					end else begin
						cnt_q   <= 2'd0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (cnt_q != 2'd3) begin
						v_q   <= r;
						cnt_q <= cnt_q + 2'd1;
					end else if (tag_we) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_tag_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		tag_we |-> !out_valid_q) else $error("tag written over a waiting tag");
	a_fin_from_c2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && $past(state_q) != ST_FIN) |-> $past(state_q) == ST_C2)
		else $error("finalization entered out of order");
	a_c1_from_c2: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C1) |-> ($past(state_q) == ST_C2 && $past(last_q)))
		else $error("length block absorbed outside a last word");
`endif

endmodule

### tb/tb_siphash_2_4_tag_top.sv
// Self-checking testbench for siphash_2_4_tag_top: streams message words, tracks the
// SipHash-2-4 state per accepted beat and compares every popped tag in order.
// Depends on siph_pkg and the siphash_2_4_tag_top RTL.
module tb_siphash_2_4_tag_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KEY_LOW_IDX  = 1'b0;
	localparam logic KEY_HIGH_IDX = 1'b1;
	localparam int   DRAIN_CYCLES = 40;
	localparam siph_pkg::word_t ALL_ONES = {64{1'b1}};

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        wr_en      = 1'b0;
	logic        wr_addr    = KEY_LOW_IDX;
	logic [63:0] wr_data    = '0;
	logic        push       = 1'b0;
	logic        full;
	logic [63:0] data_word  = '0;
	logic [3:0]  byte_count = '0;
	logic        last_word  = 1'b0;
	logic        empty;
	logic        pop        = 1'b0;
	logic [63:0] tag;

	siph_pkg::word_t expected_tags[$];
	siph_pkg::word_t key_lo, key_hi;
	siph_pkg::word_t vs[4];
	logic [7:0]      msg_len;
	logic            msg_open;

	int errors        = 0;
	int words_sent    = 0;
	int tags_checked  = 0;
	int key_settings  = 0;
	int input_stalls  = 0;
	bit tx_idle_on    = 1'b1;
	bit rx_idle_on    = 1'b1;
	int rx_hold_request = 0;

	siphash_2_4_tag_top dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.push(push), .full(full),
		.data_word(data_word), .byte_count(byte_count), .last_word(last_word),
		.empty(empty), .pop(pop), .tag(tag)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic siph_pkg::word_t rotl(input siph_pkg::word_t x, input int unsigned s);
		return (x << s) | (x >> (64 - s));
	endfunction

	task automatic sip_mix();
		siph_pkg::word_t a, b, c, d;
		a = vs[0];
		b = vs[1];
		c = vs[2];
		d = vs[3];
		a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
		c = c + d; d = rotl(d, 16); d = d ^ c;
		a = a + d; d = rotl(d, 21); d = d ^ a;
		c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
		vs[0] = a;
		vs[1] = b;
		vs[2] = c;
		vs[3] = d;
	endtask

	task automatic absorb_block(input siph_pkg::word_t m);
		vs[3] ^= m;
		sip_mix();
		sip_mix();
		vs[0] ^= m;
	endtask

	task automatic track_word(input siph_pkg::word_t d, input logic [3:0] n, input logic l);
		siph_pkg::word_t blk;
		int unsigned cnt;
		if (!msg_open) begin
			vs[0] = siph_pkg::IV0 ^ key_lo;
			vs[1] = siph_pkg::IV1 ^ key_hi;
			vs[2] = siph_pkg::IV2 ^ key_lo;
			vs[3] = siph_pkg::IV3 ^ key_hi;
			msg_len = '0;
			msg_open = 1'b1;
		end
		if (!l) begin
			absorb_block(d);
			msg_len = msg_len + 8'd8;
		end else begin
			cnt = (n > 4'd8) ? 8 : n;
			if (cnt == 8) begin
				absorb_block(d);
				msg_len = msg_len + 8'd8;
				blk = '0;
			end else begin
				msg_len = msg_len + 8'(cnt);
				blk = (cnt == 0) ? '0 : (d & (ALL_ONES >> (64 - 8 * cnt)));
			end
			blk |= {msg_len, 56'd0};
			absorb_block(blk);
			vs[2] ^= {56'd0, siph_pkg::FIN_XOR};
			repeat (4) sip_mix();
			expected_tags.push_back(vs[0] ^ vs[1] ^ vs[2] ^ vs[3]);
			msg_open = 1'b0;
		end
	endtask

	task automatic send_word(input siph_pkg::word_t d, input logic [3:0] n, input logic l);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		push       <= 1'b1;
		data_word  <= d;
		byte_count <= n;
		last_word  <= l;
		do @(posedge clk); while (full !== 1'b0);
		track_word(d, n, l);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		while (expected_tags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_keys(input siph_pkg::word_t k0, input siph_pkg::word_t k1);
		wr_en   <= 1'b1;
		wr_addr <= KEY_LOW_IDX;
		wr_data <= k0;
		@(negedge clk);
		wr_addr <= KEY_HIGH_IDX;
		wr_data <= k1;
		@(negedge clk);
		wr_en <= 1'b0;
		key_lo = k0;
		key_hi = k1;
		key_settings++;
	endtask

	function automatic siph_pkg::word_t rand_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return ALL_ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_message(input int nwords, input logic [3:0] last_cnt);
		for (int i = 0; i < nwords - 1; i++)
			send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
		send_word(rand_word(), last_cnt, 1'b1);
	endtask

	task automatic send_random_message();
		int nwords;
		logic [3:0] cnt;
		nwords = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 5);
		cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		send_message(nwords, cnt);
	endtask

	task automatic test_reset_key();
		send_word(64'h0, 4'd0, 1'b1);
		send_word(ALL_ONES, 4'd8, 1'b1);
		wait_drain();
	endtask

	task automatic test_byte_counts();
		write_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);
		for (int n = 0; n <= 8; n++)
			send_word(64'h0706050403020100, 4'(n), 1'b1);
		send_word(ALL_ONES, 4'd9, 1'b1);
		send_word(ALL_ONES, 4'd12, 1'b1);
		send_word(ALL_ONES, 4'd15, 1'b1);
		send_word(ALL_ONES, 4'd0, 1'b0);
		send_word(64'h0, 4'd15, 1'b0);
		send_word(ALL_ONES, 4'd3, 1'b1);
		wait_drain();
		write_keys(ALL_ONES, ALL_ONES);
		send_word(ALL_ONES, 4'd8, 1'b1);
		send_word(64'h0, 4'd0, 1'b1);
		wait_drain();
	endtask

	task automatic test_key_change_mid_message();
		send_word(64'h8000_0000_0000_0001, 4'd8, 1'b0);
		wait_drain();
		write_keys(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
		send_word(64'h00ff_00ff_00ff_00ff, 4'd5, 1'b1);
		send_word(64'h1, 4'd1, 1'b1);
		wait_drain();
	endtask

	task automatic test_output_backpressure();
		rx_hold_request = 200;
		for (int i = 0; i < 12; i++)
			send_message($urandom_range(1, 3), 4'($urandom_range(0, 8)));
		wait_drain();
	endtask

	task automatic test_sender_pause();
		for (int i = 0; i < 5; i++)
			send_random_message();
		wait_drain();
		for (int i = 0; i < 5; i++)
			send_random_message();
		wait_drain();
	endtask

	task automatic test_random_phase(input siph_pkg::word_t k0, input siph_pkg::word_t k1,
			input int items);
		int stop_at;
		write_keys(k0, k1);
		stop_at = words_sent + items;
		while (words_sent < stop_at) begin
			tx_idle_on = rx_idle_on && ($urandom_range(0, 3) != 0);
			send_random_message();
		end
		wait_drain();
	endtask

	always @(posedge clk) begin
		siph_pkg::word_t want;
		if (arst_n && push && full)
			input_stalls++;
		if (arst_n && pop && !empty) begin
			if (expected_tags.size() == 0) begin
				$error("tag: expected none, actual %h", tag);
				errors++;
			end else begin
				want = expected_tags.pop_front();
				if (tag !== want) begin
					$error("tag: expected %h, actual %h", want, tag);
					errors++;
				end
			end
			tags_checked++;
		end
	end

	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (rx_hold_request != 0) begin
				pop <= 1'b0;
				n = rx_hold_request;
				rx_hold_request = 0;
				repeat (n - 1) @(negedge clk);
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		key_lo = '0;
		key_hi = '0;
		vs = '{default: '0};
		msg_len = '0;
		msg_open = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_key();
		test_byte_counts();
		test_key_change_mid_message();
		test_output_backpressure();
		test_sender_pause();
		test_random_phase('0, '0, 180);
		test_random_phase(ALL_ONES, ALL_ONES, 180);
		test_random_phase({$urandom, $urandom}, {$urandom, $urandom}, 180);
		test_random_phase(ALL_ONES, '0, 150);
		rx_idle_on = 1'b0;
		test_random_phase({$urandom, $urandom}, {$urandom, $urandom}, 100);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d words into %0d checked tags under %0d key settings,",
			words_sent, tags_checked, key_settings);
		$display("with %0d cycles of input stalled by a full block.", input_stalls);
		if (errors == 0 && expected_tags.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
